// File: rtl/fln_pkg.sv
// ----------------------------------------------------------------------------
// fln_pkg
// Shared types and constants of the single-precision natural log pipeline.
// ----------------------------------------------------------------------------
package fln_pkg;

  localparam int unsigned DIV_STEPS = 39;   // quotient bits of the normalized divide
  localparam int unsigned HORNER_STEPS = 8;

  localparam logic [22:0] SQRT2_FRAC = 23'h3504F3;
  localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;
  localparam logic [31:0] MOST_NEG_FLOAT = 32'hFF7FFFFF;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  // 1/(2k+1) in Q62, truncated
  localparam logic [63:0] INV_ODD [9] = '{
    ONE_Q62 / 64'd1, ONE_Q62 / 64'd3, ONE_Q62 / 64'd5, ONE_Q62 / 64'd7,
    ONE_Q62 / 64'd9, ONE_Q62 / 64'd11, ONE_Q62 / 64'd13, ONE_Q62 / 64'd15,
    ONE_Q62 / 64'd17
  };

  typedef struct packed {
    logic              special;  // zero or negative input
    logic              dneg;     // mantissa below one
    logic signed [8:0] ex;       // unbiased exponent after range fold
    logic [5:0]        n;        // normalizing shift of |m-1|
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [38:0] zn;   // normalized z
    logic [61:0] z2;   // z squared, Q62
  } hold_t;

endpackage

// File: rtl/float32_natural_log.sv
// ----------------------------------------------------------------------------
// float32_natural_log
// Natural logarithm of single-precision bit patterns, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one item per clock while out_tvalid is low or out_tready is high;
// each item passes the 39-cell restoring divider that forms z = (m-1)/(m+1)
// and the nine two-stage multiply cells of the atanh series. The output
// register holds a result while out_tready is low, and the whole chain
// stalls with it. Zero and negative inputs return the most negative finite
// float; denormals, infinity and NaN are not treated specially.
// ----------------------------------------------------------------------------
module float32_natural_log (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] log_bits
);
  import fln_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- decode ----------------
  logic [7:0]  field;
  logic [22:0] frac;
  logic        is_nan, special, fold, dneg;
  logic [24:0] m;
  logic [22:0] ad;
  logic [25:0] s;
  logic [4:0]  tb;
  logic [5:0]  n;
  logic [62:0] dividend;
  side_t       side_nxt;

  always_comb begin
    field   = in_tdata[30:23];
    frac    = in_tdata[22:0];
    is_nan  = (field == 8'hFF) && (frac != 23'd0);
    special = (in_tdata[30:0] == 31'd0) || (in_tdata[31] && !is_nan);
    fold    = frac > SQRT2_FRAC;
    m       = fold ? {1'b0, 1'b1, frac} : {1'b1, frac, 1'b0};
    dneg    = !m[24];
    ad      = dneg ? 23'(25'h1000000 - m) : 23'(m - 25'h1000000);
    s       = {1'b0, m} + 26'h1000000;
    tb      = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (ad[i]) tb = 5'(i);
    end
    n        = 6'd62 - {1'b0, tb};
    dividend = {40'd0, ad} << n;
    side_nxt.special = special;
    side_nxt.dneg    = dneg;
    side_nxt.ex      = 9'({1'b0, field}) - 9'd127 + {8'd0, fold};
    side_nxt.n       = n;
  end

  logic        dv_valid [DIV_STEPS+1];
  logic [25:0] dv_r     [DIV_STEPS+1];
  logic [25:0] dv_s     [DIV_STEPS+1];
  logic [38:0] dv_rest  [DIV_STEPS+1];
  side_t       dv_side  [DIV_STEPS+1];

  logic        s0_valid_r;
  logic [25:0] s0_r_r, s0_s_r;
  logic [38:0] s0_rest_r;
  side_t       s0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r_r    <= {2'b00, dividend[62:39]};
      s0_s_r    <= s;
      s0_rest_r <= dividend[38:0];
      s0_side_r <= side_nxt;
    end
  end

  assign dv_valid[0] = s0_valid_r;
  assign dv_r[0]     = s0_r_r;
  assign dv_s[0]     = s0_s_r;
  assign dv_rest[0]  = s0_rest_r;
  assign dv_side[0]  = s0_side_r;

  // ---------------- divider chain ----------------
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fln_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_valid[i]),
      .in_r      (dv_r[i]),
      .in_s      (dv_s[i]),
      .in_rest   (dv_rest[i]),
      .in_side   (dv_side[i]),
      .out_valid (dv_valid[i+1]),
      .out_r     (dv_r[i+1]),
      .out_s     (dv_s[i+1]),
      .out_rest  (dv_rest[i+1]),
      .out_side  (dv_side[i+1])
    );
  end

  // ---------------- z squared ----------------
  logic [38:0] zn;
  logic [5:0]  zsh;
  logic [30:0] zq;
  logic        sz_valid_r;
  hold_t       sz_hold_r;

  always_comb begin
    zn  = dv_rest[DIV_STEPS];
    zsh = dv_side[DIV_STEPS].n - 6'd31;
    zq  = 31'(zn >> zsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sz_valid_r <= 1'b0;
    end else if (en) begin
      sz_valid_r <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sz_hold_r.side <= dv_side[DIV_STEPS];
      sz_hold_r.zn   <= zn;
      sz_hold_r.z2   <= zq * zq;
    end
  end

  // ---------------- series and final product ----------------
  logic        h_valid [HORNER_STEPS+2];
  logic [63:0] h_acc   [HORNER_STEPS+2];
  hold_t       h_hold  [HORNER_STEPS+2];

  assign h_valid[0] = sz_valid_r;
  assign h_acc[0]   = INV_ODD[8];
  assign h_hold[0]  = sz_hold_r;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    fln_mul_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (h_valid[i]),
      .in_a      (h_acc[i]),
      .in_b      ({2'b00, h_hold[i].z2}),
      .in_c      (INV_ODD[HORNER_STEPS-1-i]),
      .in_hold   (h_hold[i]),
      .out_valid (h_valid[i+1]),
      .out_y     (h_acc[i+1]),
      .out_hold  (h_hold[i+1])
    );
  end

  fln_mul_cell u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_valid[HORNER_STEPS]),
    .in_a      ({25'd0, h_hold[HORNER_STEPS].zn}),
    .in_b      (h_acc[HORNER_STEPS]),
    .in_c      (64'd0),
    .in_hold   (h_hold[HORNER_STEPS]),
    .out_valid (h_valid[HORNER_STEPS+1]),
    .out_y     (h_acc[HORNER_STEPS+1]),
    .out_hold  (h_hold[HORNER_STEPS+1])
  );

  // ---------------- exponent term and alignment ----------------
  side_t             fs;
  logic [39:0]       lmag;
  logic              c1_valid_r;
  side_t             c1_side_r;
  logic [39:0]       c1_lmag_r;
  logic [57:0]       c1_lq_r, lq_nxt;
  logic signed [65:0] c1_exl_r, exl_nxt;

  always_comb begin
    fs      = h_hold[HORNER_STEPS+1].side;
    lmag    = h_acc[HORNER_STEPS+1][39:0];
    exl_nxt = fs.ex * $signed({1'b0, LN2_Q56});
    if (fs.n <= 6'd57) begin
      lq_nxt = {18'd0, lmag} << (6'd57 - fs.n);
    end else begin
      lq_nxt = {18'd0, lmag} >> (fs.n - 6'd57);
    end
  end

  // ---------------- sum ----------------
  logic              c2_valid_r;
  side_t             c2_side_r;
  logic [39:0]       c2_lmag_r;
  logic [65:0]       c2_total_r, total_nxt;

  always_comb begin
    if (c1_side_r.dneg) begin
      total_nxt = c1_exl_r - {8'd0, c1_lq_r};
    end else begin
      total_nxt = c1_exl_r + {8'd0, c1_lq_r};
    end
  end

  // ---------------- magnitude select ----------------
  logic        c3_valid_r, c3_neg_r, c3_zero_r, c3_special_r;
  logic [63:0] c3_mag_r, mag_nxt;
  logic [7:0]  c3_e_r, e_nxt;
  logic        neg_nxt, zero_nxt;
  logic [65:0] total_abs;

  always_comb begin
    total_abs = c2_total_r[65] ? 66'(-c2_total_r) : c2_total_r;
    if (c2_side_r.ex == 9'sd0) begin
      mag_nxt  = {24'd0, c2_lmag_r};
      neg_nxt  = c2_side_r.dneg;
      e_nxt    = 8'd1 - {2'b00, c2_side_r.n};
      zero_nxt = c2_lmag_r == 40'd0;
    end else begin
      mag_nxt  = total_abs[63:0];
      neg_nxt  = c2_total_r[65];
      e_nxt    = 8'hC8;  // -56
      zero_nxt = 1'b0;
    end
  end

  // ---------------- leading one ----------------
  logic        c4_valid_r, c4_neg_r, c4_zero_r, c4_special_r;
  logic [63:0] c4_mag_r;
  logic [7:0]  c4_e_r;
  logic [5:0]  c4_p_r, p_nxt;

  always_comb begin
    p_nxt = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (c3_mag_r[i]) p_nxt = 6'(i);
    end
  end

  // ---------------- round and pack ----------------
  logic [63:0] norm;
  logic        guard, sticky, round_up, ovf;
  logic [24:0] kr;
  logic [9:0]  bsum;
  logic [31:0] res_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  always_comb begin
    norm     = c4_mag_r << (6'd63 - c4_p_r);
    guard    = norm[39];
    sticky   = |norm[38:0];
    round_up = guard && (sticky || norm[40]);
    kr       = {1'b0, norm[63:40]} + {24'd0, round_up};
    ovf      = kr[24];
    bsum     = {4'd0, c4_p_r} + {{2{c4_e_r[7]}}, c4_e_r} + 10'd127 + {9'd0, ovf};
    if (c4_special_r) begin
      res_nxt = MOST_NEG_FLOAT;
    end else if (c4_zero_r) begin
      res_nxt = 32'd0;
    end else begin
      res_nxt = {c4_neg_r, bsum[7:0], ovf ? 23'd0 : kr[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r  <= 1'b0;
      c2_valid_r  <= 1'b0;
      c3_valid_r  <= 1'b0;
      c4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      c1_valid_r  <= h_valid[HORNER_STEPS+1];
      c2_valid_r  <= c1_valid_r;
      c3_valid_r  <= c2_valid_r;
      c4_valid_r  <= c3_valid_r;
      out_valid_r <= c4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_side_r    <= fs;
      c1_lmag_r    <= lmag;
      c1_lq_r      <= lq_nxt;
      c1_exl_r     <= exl_nxt;
      c2_side_r    <= c1_side_r;
      c2_lmag_r    <= c1_lmag_r;
      c2_total_r   <= total_nxt;
      c3_mag_r     <= mag_nxt;
      c3_neg_r     <= neg_nxt;
      c3_e_r       <= e_nxt;
      c3_zero_r    <= zero_nxt;
      c3_special_r <= c2_side_r.special;
      c4_mag_r     <= c3_mag_r;
      c4_neg_r     <= c3_neg_r;
      c4_e_r       <= c3_e_r;
      c4_zero_r    <= c3_zero_r;
      c4_special_r <= c3_special_r;
      c4_p_r       <= p_nxt;
      out_data_r   <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_zero_special: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[30:0] == 31'd0) |=> s0_valid_r && s0_side_r.special)
    else $error("zero input not flagged as special");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid[DIV_STEPS] |-> dv_r[DIV_STEPS] < dv_s[DIV_STEPS])
    else $error("divider remainder not below divisor");

  a_norm_top: assert property (@(posedge clk) disable iff (!rst_n)
    c4_valid_r && (c4_mag_r != 64'd0) |-> norm[63])
    else $error("normalized magnitude lost its leading one");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

// File: rtl/fln_div_cell.sv
// ----------------------------------------------------------------------------
// fln_div_cell
// One restoring-division step: shift in a dividend bit, subtract the divisor
// when it fits, shift the quotient bit into the vacated low end.
// ----------------------------------------------------------------------------
module fln_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [25:0]         in_r,
  input  logic [25:0]         in_s,
  input  logic [38:0]         in_rest,
  input  fln_pkg::side_t      in_side,
  output logic                out_valid,
  output logic [25:0]         out_r,
  output logic [25:0]         out_s,
  output logic [38:0]         out_rest,
  output fln_pkg::side_t      out_side
);
  import fln_pkg::*;

  logic        valid_r;
  logic [25:0] r_r, r_nxt, s_r;
  logic [38:0] rest_r, rest_nxt;
  side_t       side_r;
  logic [26:0] trial;
  logic        fits;

  always_comb begin
    trial    = {in_r, in_rest[38]};
    fits     = trial >= {1'b0, in_s};
    r_nxt    = fits ? 26'(trial - {1'b0, in_s}) : trial[25:0];
    rest_nxt = {in_rest[37:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= r_nxt;
      s_r    <= in_s;
      rest_r <= rest_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_r     = r_r;
  assign out_s     = s_r;
  assign out_rest  = rest_r;
  assign out_side  = side_r;

endmodule

// File: rtl/fln_mul_cell.sv
// ----------------------------------------------------------------------------
// fln_mul_cell
// Two-stage Q62 multiply-add: y = ((a*b) >> 62) + c, from four registered
// 32x32 partial products.
// ----------------------------------------------------------------------------
module fln_mul_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    in_a,
  input  logic [63:0]    in_b,
  input  logic [63:0]    in_c,
  input  fln_pkg::hold_t in_hold,
  output logic           out_valid,
  output logic [63:0]    out_y,
  output fln_pkg::hold_t out_hold
);
  import fln_pkg::*;

  logic        v1_r, v2_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r, c_r;
  logic [63:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  hold_t       h1_r, h2_r;
  logic [127:0] prod;
  logic [63:0] y_r, y_nxt;

  always_comb begin
    p00_nxt = in_a[31:0] * in_b[31:0];
    p01_nxt = in_a[31:0] * in_b[63:32];
    p10_nxt = in_a[63:32] * in_b[31:0];
    p11_nxt = in_a[63:32] * in_b[63:32];
  end

  always_comb begin
    prod = {p11_r, 64'd0} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
         + {64'd0, p00_r};
    y_nxt = prod[125:62] + c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      c_r   <= in_c;
      h1_r  <= in_hold;
      y_r   <= y_nxt;
      h2_r  <= h1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_y     = y_r;
  assign out_hold  = h2_r;

endmodule
